// ===== sv/nsr_pkg.sv =====
package nsr_pkg;

  // Field widths
  localparam int unsigned RadW  = 31;               // radicand, unsigned integer
  localparam int unsigned RootW = 32;               // root, unsigned Q16.16
  localparam int unsigned FracW = 16;               // fraction bits of the root
  localparam int unsigned DvdW  = RadW + 2 * FracW; // scaled radicand N = x << 32
  localparam int unsigned EstW  = RadW + FracW;     // estimate, up to (2^31) << 15
  localparam int unsigned DivSteps = DvdW;          // one quotient bit per cycle
  localparam int unsigned CntW  = $clog2(DivSteps);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture radicand, set first estimate
    logic div_init;  // start a division N / est
    logic div_step;  // one restoring division step
    logic update;    // take the new estimate
    logic store;     // move the result into the output register
  } nsr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic zero;      // radicand is zero
    logic cnt_zero;  // current division step is the last one
    logic converged; // new estimate is not below the current one
  } nsr_sts_t;

endpackage

// ===== sv/nsr_dp.sv =====
module nsr_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  nsr_pkg::nsr_cmd_t          cmd_i,
  output nsr_pkg::nsr_sts_t          sts_o,
  input  logic [nsr_pkg::RadW-1:0]   radicand_i,
  output logic [nsr_pkg::RootW-1:0]  root_o
);

  logic [nsr_pkg::RadW-1:0]   x_q;
  logic [nsr_pkg::EstW-1:0]   est_q, est_d;
  logic [nsr_pkg::DvdW-1:0]   dvd_q, dvd_d;
  logic [nsr_pkg::EstW-1:0]   rem_q, rem_d;
  logic [nsr_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [nsr_pkg::RootW-1:0]  root_q;
  logic [nsr_pkg::EstW:0]     rem_sh, sum;
  logic [nsr_pkg::EstW-1:0]   nxt;
  logic                       ge;

  // Restoring division step: shift in the next dividend bit, subtract if it fits.
  // The dividend register fills with quotient bits from the bottom.
  always_comb begin
    rem_sh = {rem_q, dvd_q[nsr_pkg::DvdW-1]};
    ge     = rem_sh >= {1'b0, est_q};
    rem_d  = ge ? nsr_pkg::EstW'(rem_sh - {1'b0, est_q})
                : nsr_pkg::EstW'(rem_sh);
    dvd_d  = {dvd_q[nsr_pkg::DvdW-2:0], ge};
    cnt_d  = cnt_q - nsr_pkg::CntW'(1);
  end

  // Newton update: next = (N / est + est) >> 1; quotient stays below 2^47
  assign sum = {1'b0, dvd_q[nsr_pkg::EstW-1:0]} + {1'b0, est_q};
  assign nxt = sum[nsr_pkg::EstW:1];

  // First estimate is (1.0 + N/1.0) / 2 = (x + 1) << 15
  assign est_d = {({1'b0, radicand_i} + 32'd1), 15'd0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q   <= radicand_i;
      est_q <= est_d;
    end else if (cmd_i.update) begin
      est_q <= nxt;
    end
    if (cmd_i.div_init) begin
      dvd_q <= {x_q, {(2 * nsr_pkg::FracW){1'b0}}};
      rem_q <= '0;
      cnt_q <= nsr_pkg::CntW'(nsr_pkg::DivSteps - 1);
    end else if (cmd_i.div_step) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
      cnt_q <= cnt_d;
    end
    if (cmd_i.store) begin
      root_q <= (x_q == '0) ? '0 : est_q[nsr_pkg::RootW-1:0];
    end
  end

  assign sts_o.zero      = (x_q == '0);
  assign sts_o.cnt_zero  = (cnt_q == '0);
  assign sts_o.converged = (nxt >= est_q);
  assign root_o          = root_q;

  // Estimates only fall while iterating
  a_est_falls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> est_q < $past(est_q))
    else $error("estimate did not decrease on update");

  // Partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |=> rem_q < est_q)
    else $error("division remainder out of range");

  // Final estimate fits the root field
  a_root_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.store && x_q != '0) |-> est_q[nsr_pkg::EstW-1:nsr_pkg::RootW] == '0)
    else $error("root exceeds 32 bits");

endmodule

// ===== sv/nsr_ctrl.sv =====
module nsr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output nsr_pkg::nsr_cmd_t cmd_o,
  input  nsr_pkg::nsr_sts_t sts_i
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StInit  = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StCheck = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);

  // Sequencing: load, then divide / update until the estimate stops falling; a zero radicand goes straight to done
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StInit;
        end
      end
      StInit: begin
        if (sts_i.zero) begin
          state_d = StDone;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.cnt_zero) state_d = StCheck;
      end
      StCheck: begin
        if (sts_i.converged) begin
          state_d = StDone;
        end else begin
          cmd_o.update = 1'b1;
          state_d      = StInit;
        end
      end
      StDone: begin
        if (slot_free) begin
          cmd_o.store = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Output register valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.store) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // Never overwrite a result that has not been transferred
  a_store_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.store |-> slot_free)
    else $error("result overwritten before transfer");

  // A result appears only through a store
  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.store))
    else $error("output valid without store");

  // Division always ends in the check state
  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && sts_i.cnt_zero) |=> state_q == StCheck)
    else $error("division did not end in check");

endmodule

// ===== sv/newton_square_root.sv =====
// Channel  Direction  Signals                          Payload
// in       input      in_valid_i / in_ready_o          radicand_i [30:0] unsigned integer
// out      output     out_valid_o / out_ready_i        root_o [31:0] unsigned Q16.16
//
// Each Newton step divides N = radicand << 32 by the estimate in a bit-serial
// restoring divider (states StInit and StDiv), then StCheck takes the new estimate.
// A zero radicand skips the division and goes from StInit straight to StDone.
// Reset (rst_ni, asynchronous, active low) clears the controller and output valid.
// A new radicand is taken once the previous result sits in the output register;
// a stalled output holds the finished item until that register is free.
module newton_square_root (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [nsr_pkg::RadW-1:0]   radicand_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [nsr_pkg::RootW-1:0]  root_o
);

  nsr_pkg::nsr_cmd_t cmd;
  nsr_pkg::nsr_sts_t sts;

  nsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  nsr_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .radicand_i (radicand_i),
    .root_o     (root_o)
  );

endmodule
